/* hw/rtl/dhka_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhka_pkg
// Shared widths, types and register indexes for the key agreement block.
// ----------------------------------------------------------------------------
package dhka_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic [DATA_W-1:0]    word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PRIME_MODULUS  = CFG_IDX_W'(0);
    localparam cfg_idx_t REG_GENERATOR_BASE = CFG_IDX_W'(1);

    localparam word_t WORD_ONE       = DATA_W'(1);
    localparam word_t PRIME_RESET    = DATA_W'(23);
    localparam word_t GENERATOR_RESET = DATA_W'(5);

endpackage : dhka_pkg
`default_nettype wire

/* hw/rtl/diffie_hellman_key_agreement_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// diffie_hellman_key_agreement_top
// Both public values and both shared keys of a Diffie-Hellman exchange over
// one shared modular multiplier.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_ready is high only while idle. The
// generator is first reduced mod p, then four modular exponentiations run
// in turn by square-and-multiply on the single shift-and-add modular
// multiplier, which works through its second operand bit by bit up to the
// highest set bit. Small exponents finish sooner than large ones. A modulus
// below 2 gives all zeros and keys_match high. The result sits in an output
// register, so a new item can be taken while the previous result waits.
// Configuration must be written only while idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module diffie_hellman_key_agreement_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire dhka_pkg::word_t    first_secret,
    input  wire dhka_pkg::word_t    second_secret,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output dhka_pkg::word_t         first_public,
    output dhka_pkg::word_t         second_public,
    output dhka_pkg::word_t         first_key,
    output dhka_pkg::word_t         second_key,
    output logic                    keys_match,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire dhka_pkg::cfg_idx_t cfg_index,
    input  wire dhka_pkg::word_t    cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RED    = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_MR     = 3'd4;
    localparam logic [2:0] S_MB     = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    localparam logic [1:0] POW_PUB1 = 2'd0;
    localparam logic [1:0] POW_PUB2 = 2'd1;
    localparam logic [1:0] POW_KEY1 = 2'd2;
    localparam logic [1:0] POW_KEY2 = 2'd3;

    logic [2:0]      state_reg, state_next;
    logic [1:0]      idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    dhka_pkg::word_t prime_reg, prime_next;
    dhka_pkg::word_t gen_reg, gen_next;

    dhka_pkg::word_t s1_reg, s1_next;
    dhka_pkg::word_t s2_reg, s2_next;
    dhka_pkg::word_t b0_reg, b0_next;
    dhka_pkg::word_t base_reg, base_next;
    dhka_pkg::word_t exp_reg, exp_next;
    dhka_pkg::word_t res_reg, res_next;
    dhka_pkg::word_t pub1_reg, pub1_next;
    dhka_pkg::word_t pub2_reg, pub2_next;
    dhka_pkg::word_t key1_reg, key1_next;
    dhka_pkg::word_t key2_reg, key2_next;
    dhka_pkg::word_t o_pub1_reg, o_pub1_next;
    dhka_pkg::word_t o_pub2_reg, o_pub2_next;
    dhka_pkg::word_t o_key1_reg, o_key1_next;
    dhka_pkg::word_t o_key2_reg, o_key2_next;
    logic            o_match_reg, o_match_next;

    logic            mm_start;
    dhka_pkg::word_t mm_a;
    dhka_pkg::word_t mm_b;
    logic            mm_done;
    dhka_pkg::word_t mm_result;

    dhka_modmul u_modmul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .m      (prime_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        prime_next = prime_reg;
        gen_next   = gen_reg;
        if (cfg_valid)
        begin
            if (cfg_index == dhka_pkg::REG_PRIME_MODULUS)
            begin
                prime_next = cfg_data;
            end
            else if (cfg_index == dhka_pkg::REG_GENERATOR_BASE)
            begin
                gen_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        b0_next        = b0_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        res_next       = res_reg;
        pub1_next      = pub1_reg;
        pub2_next      = pub2_reg;
        key1_next      = key1_reg;
        key2_next      = key2_reg;
        o_pub1_next    = o_pub1_reg;
        o_pub2_next    = o_pub2_reg;
        o_key1_next    = o_key1_reg;
        o_key2_next    = o_key2_reg;
        o_match_next   = o_match_reg;
        mm_start       = 1'b0;
        mm_a           = base_reg;
        mm_b           = base_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    s1_next = first_secret;
                    s2_next = second_secret;
                    if (prime_reg < dhka_pkg::DATA_W'(2))
                    begin
                        pub1_next  = '0;
                        pub2_next  = '0;
                        key1_next  = '0;
                        key2_next  = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // generator mod p as 1 * generator
                        mm_start   = 1'b1;
                        mm_a       = dhka_pkg::WORD_ONE;
                        mm_b       = gen_reg;
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                if (mm_done)
                begin
                    b0_next    = mm_result;
                    idx_next   = POW_PUB1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                res_next = dhka_pkg::WORD_ONE;
                unique case (idx_reg)
                    POW_PUB1:
                    begin
                        base_next = b0_reg;
                        exp_next  = s1_reg;
                    end
                    POW_PUB2:
                    begin
                        base_next = b0_reg;
                        exp_next  = s2_reg;
                    end
                    POW_KEY1:
                    begin
                        base_next = pub2_reg;
                        exp_next  = s1_reg;
                    end
                    default:
                    begin
                        base_next = pub1_reg;
                        exp_next  = s2_reg;
                    end
                endcase
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (exp_reg == '0)
                begin
                    unique case (idx_reg)
                        POW_PUB1: pub1_next = res_reg;
                        POW_PUB2: pub2_next = res_reg;
                        POW_KEY1: key1_next = res_reg;
                        default:  key2_next = res_reg;
                    endcase
                    if (idx_reg == POW_KEY2)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_LOAD;
                    end
                end
                else if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_a       = res_reg;
                    state_next = S_MR;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = S_MB;
                end
            end
            S_MR:
            begin
                if (mm_done)
                begin
                    res_next = mm_result;
                    // last exponent bit: squaring not needed
                    if (exp_reg[dhka_pkg::DATA_W-1:1] == '0)
                    begin
                        exp_next   = '0;
                        state_next = S_STEP;
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        state_next = S_MB;
                    end
                end
            end
            S_MB:
            begin
                if (mm_done)
                begin
                    base_next  = mm_result;
                    exp_next   = exp_reg >> 1;
                    state_next = S_STEP;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    o_pub1_next    = pub1_reg;
                    o_pub2_next    = pub2_reg;
                    o_key1_next    = key1_reg;
                    o_key2_next    = key2_reg;
                    o_match_next   = (key1_reg == key2_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= POW_PUB1;
            out_valid_reg <= 1'b0;
            prime_reg     <= dhka_pkg::PRIME_RESET;
            gen_reg       <= dhka_pkg::GENERATOR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            prime_reg     <= prime_next;
            gen_reg       <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        b0_reg      <= b0_next;
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        res_reg     <= res_next;
        pub1_reg    <= pub1_next;
        pub2_reg    <= pub2_next;
        key1_reg    <= key1_next;
        key2_reg    <= key2_next;
        o_pub1_reg  <= o_pub1_next;
        o_pub2_reg  <= o_pub2_next;
        o_key1_reg  <= o_key1_next;
        o_key2_reg  <= o_key2_next;
        o_match_reg <= o_match_next;
    end

    assign out_valid     = out_valid_reg;
    assign first_public  = o_pub1_reg;
    assign second_public = o_pub2_reg;
    assign first_key     = o_key1_reg;
    assign second_key    = o_key2_reg;
    assign keys_match    = o_match_reg;

`ifndef NO_ASSERTIONS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == S_RED || state_reg == S_MR || state_reg == S_MB))
        else $error("multiplier done outside a wait state");

    a_match_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_match_reg == (o_key1_reg == o_key2_reg)))
        else $error("keys_match disagrees with keys");
`endif

endmodule : diffie_hellman_key_agreement_top
`default_nettype wire

/* hw/rtl/dhka_modmul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhka_modmul
// Shift-and-add modular multiplier: result = (a * b) mod m, one multiplier
// bit per cycle, LSB first, stopping once the remaining multiplier is zero.
// Requires a < m and m >= 2; b may take any value.
// ----------------------------------------------------------------------------
module dhka_modmul
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire dhka_pkg::word_t a,
    input  wire dhka_pkg::word_t b,
    input  wire dhka_pkg::word_t m,
    output logic                done,
    output dhka_pkg::word_t     result
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    dhka_pkg::word_t a_reg, a_next;
    dhka_pkg::word_t b_reg, b_next;
    dhka_pkg::word_t acc_reg, acc_next;

    // (x + y) mod m for x, y < m
    function automatic dhka_pkg::word_t add_mod(
        input dhka_pkg::word_t x,
        input dhka_pkg::word_t y,
        input dhka_pkg::word_t md
    );
        logic [dhka_pkg::DATA_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, md})
        begin
            s = s - {1'b0, md};
        end
        return s[dhka_pkg::DATA_W-1:0];
    endfunction

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = add_mod(acc_reg, a_reg, m);
                end
                a_next = add_mod(a_reg, a_reg, m);
                b_next = b_reg >> 1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

`ifndef NO_ASSERTIONS
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (acc_reg < m))
        else $error("modmul accumulator not reduced");

    a_addend_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (a_reg < m))
        else $error("modmul addend not reduced");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && !$past(done_reg)))
        else $error("modmul done while busy or held");
`endif

endmodule : dhka_modmul
`default_nettype wire
